@@ design/sea_pkg.sv @@
`timescale 1ns / 1ps
package sea_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAMP_W = 48;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = 64;
    localparam int WORD_W  = STAMP_W + VAL_W;
    localparam int DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP_RD,
        ST_SKIP_CMP,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_en;
        logic q_start;
        logic skip_step;
        logic walk_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic lead_end;
        logic trail_end;
        logic skip_lt;
        logic out_free;
    } t_stat;

endpackage

@@ design/sea_ram.sv @@
`timescale 1ns / 1ps
module sea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ design/sea_ctrl.sv @@
`timescale 1ns / 1ps
module sea_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_op,
    input  sea_pkg::t_stat i_stat,
    output logic          o_s_tready,
    output sea_pkg::t_cmd o_cmd
);
    import sea_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_op == OP_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_state       = ST_SKIP_RD;
                    end else begin
                        o_cmd.load_en = 1'b1;
                    end
                end
            end
            ST_SKIP_RD: begin
                n_state = i_stat.lead_end ? ST_WALK_RD : ST_SKIP_CMP;
            end
            ST_SKIP_CMP: begin
                if (i_stat.skip_lt) begin
                    o_cmd.skip_step = 1'b1;
                    n_state         = ST_SKIP_RD;
                end else begin
                    n_state = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                n_state = (i_stat.lead_end || i_stat.trail_end) ? ST_DONE : ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = ST_WALK_RD;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/sea_dpath.sv @@
`timescale 1ns / 1ps
module sea_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sea_pkg::t_cmd                 i_cmd,
    input  logic                          i_first,
    input  logic [sea_pkg::STAMP_W-1:0]   i_stamp,
    input  logic [sea_pkg::VAL_W-1:0]     i_count_value,
    input  logic [sea_pkg::STAMP_W-1:0]   i_lag,
    input  logic                          i_m_tready,
    output sea_pkg::t_stat                o_stat,
    output logic                          o_m_tvalid,
    output logic [sea_pkg::STAMP_W-1:0]   o_lag_echo,
    output logic [sea_pkg::SUM_W-1:0]     o_corr_sum,
    output logic                          o_truncated
);
    import sea_pkg::*;

    logic [CNT_W-1:0]   r_fill;
    logic               r_ovf;
    logic [STAMP_W-1:0] r_lag;
    logic [CNT_W-1:0]   r_trail;
    logic [CNT_W-1:0]   r_lead;
    logic [SUM_W-1:0]   r_sum;
    logic [PROD_W-1:0]  r_prod;
    logic               r_prod_v;
    logic               r_out_valid;
    logic [STAMP_W-1:0] r_out_lag;
    logic [SUM_W-1:0]   r_out_sum;
    logic               r_out_trunc;

    logic               full;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  rd_trail;
    logic [WORD_W-1:0]  rd_lead;
    logic [STAMP_W-1:0] trail_time;
    logic [STAMP_W-1:0] lead_time;
    logic [VAL_W-1:0]   trail_val;
    logic [VAL_W-1:0]   lead_val;
    logic [STAMP_W:0]   shifted;
    logic [STAMP_W:0]   target;

    assign full  = (r_fill >= CNT_W'(DEPTH));
    assign we    = i_cmd.load_en && (i_first || !full);
    assign waddr = i_first ? '0 : r_fill[ADDR_W-1:0];

    sea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   ({i_count_value, i_stamp}),
        .i_raddr_a (r_trail[ADDR_W-1:0]),
        .i_raddr_b (r_lead[ADDR_W-1:0]),
        .o_rdata_a (rd_trail),
        .o_rdata_b (rd_lead)
    );

    assign trail_time = rd_trail[STAMP_W-1:0];
    assign trail_val  = rd_trail[WORD_W-1:STAMP_W];
    assign lead_time  = rd_lead[STAMP_W-1:0];
    assign lead_val   = rd_lead[WORD_W-1:STAMP_W];
    assign shifted    = {1'b0, trail_time} + {1'b0, r_lag};
    assign target     = {1'b0, lead_time};

    assign o_stat.lead_end  = (r_lead >= r_fill);
    assign o_stat.trail_end = (r_trail >= r_fill);
    assign o_stat.skip_lt   = (lead_time < r_lag);
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_en) begin
                if (i_first) begin
                    r_fill <= CNT_W'(1);
                    r_ovf  <= 1'b0;
                end else if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            r_prod_v <= i_cmd.walk_step && (shifted == target);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(trail_val) * PROD_W'(lead_val);
        if (i_cmd.q_start) begin
            r_lag   <= i_lag;
            r_trail <= '0;
            r_lead  <= '0;
            r_sum   <= '0;
        end else begin
            if (r_prod_v) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
            if (i_cmd.skip_step) begin
                r_lead <= r_lead + CNT_W'(1);
            end
            if (i_cmd.walk_step) begin
                if (shifted == target) begin
                    r_trail <= r_trail + CNT_W'(1);
                    r_lead  <= r_lead + CNT_W'(1);
                end else if (shifted < target) begin
                    r_trail <= r_trail + CNT_W'(1);
                end else begin
                    r_lead <= r_lead + CNT_W'(1);
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_lag   <= r_lag;
            r_out_sum   <= r_sum;
            r_out_trunc <= r_ovf;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_lag_echo  = r_out_lag;
    assign o_corr_sum  = r_out_sum;
    assign o_truncated = r_out_trunc;

endmodule

@@ design/sparse_event_autocorrelator.sv @@
`timescale 1ns / 1ps
// Load item: the controller stays idle, so the next item is accepted in the following cycle.
// Query item: the lead pointer first skips samples stamped below the lag, then both pointers walk the set;
// each pointer step is a read state then a compare state, as the two-read-port sample memory is registered.
// The result sits in an output register; loads and the next query are taken while it waits.
// Reset (synchronous, active low) empties the sample set and clears the truncated flag;
// sample memory contents are not cleared.
module sparse_event_autocorrelator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [sea_pkg::DATA_W-1:0]   i_s_tdata,  // stamp, count_value, lag
    input  logic [sea_pkg::IN_USER_W-1:0] i_s_tuser, // op, first
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [sea_pkg::DATA_W-1:0]   o_m_tdata,  // lag_echo, corr_sum
    output logic [sea_pkg::OUT_USER_W-1:0] o_m_tuser // truncated
);
    import sea_pkg::*;

    t_cmd               cmd;
    t_stat              stat;
    logic [STAMP_W-1:0] lag_echo;
    logic [SUM_W-1:0]   corr_sum;
    logic               truncated;

    sea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser[0]),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    sea_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_first       (i_s_tuser[1]),
        .i_stamp       (i_s_tdata[STAMP_W-1:0]),
        .i_count_value (i_s_tdata[STAMP_W+VAL_W-1:STAMP_W]),
        .i_lag         (i_s_tdata[2*STAMP_W+VAL_W-1:STAMP_W+VAL_W]),
        .i_m_tready    (i_m_tready),
        .o_stat        (stat),
        .o_m_tvalid    (o_m_tvalid),
        .o_lag_echo    (lag_echo),
        .o_corr_sum    (corr_sum),
        .o_truncated   (truncated)
    );

    assign o_m_tdata = {corr_sum, lag_echo};
    assign o_m_tuser = truncated;

    a_walk_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !(stat.lead_end || stat.trail_end))
        else $error("walk step past end of sample set");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a waiting item");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_en, cmd.q_start, cmd.skip_step, cmd.walk_step, cmd.out_load}))
        else $error("more than one command at once");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0] == OP_QUERY) |=> !o_s_tready)
        else $error("input taken while a query is running");

endmodule

@@ test/sparse_event_autocorrelator_test.sv @@
`timescale 1ns / 1ps
module sparse_event_autocorrelator_test;
    import sea_pkg::*;

    localparam logic [STAMP_W-1:0] STAMP_MAX   = {STAMP_W{1'b1}};
    localparam int                 STALL_LIMIT = 20000;
    localparam int                 DRAIN_WAIT  = 4 * DEPTH + 8;

    typedef struct {
        logic [STAMP_W-1:0] lag;
        logic [SUM_W-1:0]   sum;
        logic               trunc;
    } t_corr_result;

    class t_corr_board;
        logic [STAMP_W-1:0] time_mem[DEPTH];
        logic [VAL_W-1:0]   value_mem[DEPTH];
        int                 fill = 0;
        logic               overflow = 1'b0;
        t_corr_result       expected_q[$];
        int                 errors = 0;

        function logic [SUM_W-1:0] walk_sum(logic [STAMP_W-1:0] lag);
            int               trail;
            int               lead;
            logic [SUM_W-1:0] acc;
            logic [STAMP_W:0] shifted;
            logic [STAMP_W:0] target;
            trail = 0;
            lead  = 0;
            acc   = '0;
            while (lead < fill && time_mem[lead] < lag) lead++;
            while (trail < fill && lead < fill) begin
                shifted = {1'b0, time_mem[trail]} + {1'b0, lag};
                target  = {1'b0, time_mem[lead]};
                if (shifted == target) begin
                    acc = acc + SUM_W'(value_mem[trail]) * SUM_W'(value_mem[lead]);
                    trail++;
                    lead++;
                end else if (shifted < target) begin
                    trail++;
                end else begin
                    lead++;
                end
            end
            return acc;
        endfunction

        function void note_item(logic op, logic first, logic [STAMP_W-1:0] stamp,
                                logic [VAL_W-1:0] cnt, logic [STAMP_W-1:0] lag);
            t_corr_result res;
            if (op == OP_LOAD) begin
                if (first) begin
                    fill     = 0;
                    overflow = 1'b0;
                end
                if (fill < DEPTH) begin
                    time_mem[fill]  = stamp;
                    value_mem[fill] = cnt;
                    fill++;
                end else begin
                    overflow = 1'b1;
                end
            end else begin
                res.lag   = lag;
                res.sum   = walk_sum(lag);
                res.trunc = overflow;
                expected_q = {expected_q, res};
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_corr_result       want;
            logic [STAMP_W-1:0] got_lag;
            logic [SUM_W-1:0]   got_sum;
            logic               got_trunc;
            got_lag   = data[STAMP_W-1:0];
            got_sum   = data[STAMP_W +: SUM_W];
            got_trunc = user[0];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item lag_echo %h corr_sum %h truncated %b",
                         $time, got_lag, got_sum, got_trunc);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got_lag !== want.lag) begin
                $display("%0t: lag_echo expected %h actual %h", $time, want.lag, got_lag);
                errors++;
            end
            if (got_sum !== want.sum) begin
                $display("%0t: corr_sum expected %h actual %h", $time, want.sum, got_sum);
                errors++;
            end
            if (got_trunc !== want.trunc) begin
                $display("%0t: truncated expected %b actual %b", $time, want.trunc, got_trunc);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata = '0;     // stamp, count_value, lag
    logic [IN_USER_W-1:0]  i_s_tuser = '0;     // op, first
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [DATA_W-1:0]     o_m_tdata;          // lag_echo, corr_sum
    logic [OUT_USER_W-1:0] o_m_tuser;          // truncated

    t_corr_board        board = new;
    int                 send_idle_pct = 0;
    int                 sink_stall_pct = 0;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;
    logic [STAMP_W-1:0] set_stamps[$];

    sparse_event_autocorrelator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata, o_m_tuser);
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [STAMP_W-1:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic logic [VAL_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '1;
        if (sel == 1) return '0;
        return VAL_W'($urandom());
    endfunction

    function automatic logic [STAMP_W-1:0] pick_lag();
        int sel;
        int a;
        int b;
        sel = $urandom_range(99);
        if (set_stamps.size() == 0 || sel < 15) return rand48();
        if (sel < 25) return '0;
        if (sel < 32) return STAMP_MAX;
        a = $urandom_range(set_stamps.size() - 1);
        b = $urandom_range(set_stamps.size() - 1);
        if (a > b) return set_stamps[a] - set_stamps[b];
        return set_stamps[b] - set_stamps[a];
    endfunction

    task automatic send_item(input logic op, input logic first, input logic [STAMP_W-1:0] stamp,
                             input logic [VAL_W-1:0] cnt, input logic [STAMP_W-1:0] lag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {lag, cnt, stamp};
        i_s_tuser  = {first, op};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_item(op, first, stamp, cnt, lag);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_query();
        send_item(OP_QUERY, 1'($urandom()), rand48(), VAL_W'($urandom()), pick_lag());
    endtask

    task automatic run_set(input int n_loads, input int n_queries);
        logic [STAMP_W-1:0] stamp;
        int                 sel;
        sel = $urandom_range(3);
        stamp = (sel == 0) ? '0 : (sel == 1) ? STAMP_MAX - 48'd200 : rand48();
        set_stamps.delete();
        for (int k = 0; k < n_loads; k++) begin
            // occasionally break the ordering
            if ($urandom_range(19) == 0) begin
                stamp = rand48();
            end else if (k > 0) begin
                stamp = stamp + STAMP_W'($urandom_range(3));
            end
            set_stamps = {set_stamps, stamp};
            send_item(OP_LOAD, k == 0, stamp, pick_count(), rand48());
            if (k > 0 && $urandom_range(15) == 0) send_query();
        end
        repeat (n_queries) send_query();
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                sink_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 45;
                sink_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                sink_stall_pct = 45;
            end
            default: begin
                send_idle_pct  = 22;
                sink_stall_pct = 22;
            end
        endcase
    endtask

    initial begin
        int set_idx;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty set
        send_item(OP_QUERY, 1'b1, STAMP_MAX, 16'hFFFF, 48'd0);
        // equal stamps, full-scale counts
        send_item(OP_LOAD, 1'b1, 48'd0,  16'hFFFF, STAMP_MAX);
        send_item(OP_LOAD, 1'b0, 48'd0,  16'hFFFF, 48'd0);
        send_item(OP_LOAD, 1'b0, 48'd5,  16'd1,    STAMP_MAX);
        send_item(OP_LOAD, 1'b0, 48'd5,  16'd2,    48'd3);
        send_item(OP_LOAD, 1'b0, 48'd10, 16'h8000, 48'd0);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, 48'd0);
        send_item(OP_QUERY, 1'b1, 48'd7, 16'd9, 48'd5);
        send_item(OP_QUERY, 1'b0, STAMP_MAX, 16'hFFFF, 48'd10);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, 48'd11);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, STAMP_MAX);
        // top of the stamp range
        send_item(OP_LOAD, 1'b1, STAMP_MAX - 48'd1, 16'd3, 48'd0);
        send_item(OP_LOAD, 1'b0, STAMP_MAX, 16'd7, STAMP_MAX);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, 48'd1);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, STAMP_MAX);
        send_item(OP_QUERY, 1'b1, 48'd0, 16'd0, 48'd0);
        // unordered stamps
        send_item(OP_LOAD, 1'b1, 48'd20, 16'd9, 48'd0);
        send_item(OP_LOAD, 1'b0, 48'd10, 16'd4, 48'd0);
        send_item(OP_LOAD, 1'b0, 48'd30, 16'd6, 48'd0);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, 48'd10);
        send_item(OP_QUERY, 1'b0, 48'd0, 16'd0, 48'd20);

        set_idx = 0;
        while (items_sent < 270) begin
            set_idling((set_idx / 5) % 4);
            run_set($urandom_range(1, 20), $urandom_range(1, 4));
            set_idx++;
        end
        // restart the set
        set_idling(0);
        run_set($urandom_range(1, 20), 2);

        i_s_tvalid = 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/sea_pkg.sv
design/sea_ram.sv
design/sea_ctrl.sv
design/sea_dpath.sv
design/sparse_event_autocorrelator.sv
test/sparse_event_autocorrelator_test.sv
